// File: rtl/core/kkgf_pkg.sv
package kkgf_pkg;

  localparam int unsigned MAX_NODES_DEF   = 256;
  localparam int unsigned MAX_EDGES_DEF   = 32768;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_FETCH = 2'd2;

  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_EDGE    = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic [1:0] CFG_NODE_COUNT    = 2'd0;
  localparam logic [1:0] CFG_TARGET_GROUPS = 2'd1;

  localparam logic [8:0]  NODE_COUNT_RST = 9'd256;
  localparam logic [8:0]  TARGET_RST     = 9'd1;
  localparam logic [30:0] W31_MAX        = 31'h7FFF_FFFF;
  localparam logic [15:0] RANK_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  end_a;
    logic [8:0]  end_b;
    logic [15:0] weight;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [30:0] dropped_weight;
    logic [15:0] dropped_count;
    logic [8:0]  out_a;
    logic [8:0]  out_b;
    logic        is_last;
  } out_t;

endpackage

// File: rtl/core/kkgf_ram.sv
module kkgf_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  logic [DATA_W-1:0]          wdata_i,
  input  logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [DATA_W-1:0]          rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kruskal_k_group_forest_unit.sv
// Channel | Direction | Beat content                    | Accepted when
// in      | input     | kkgf_pkg::in_t  (mode, edge)    | in_valid_i  & in_ready_o
// out     | output    | kkgf_pkg::out_t (result)        | out_valid_o & out_ready_i
// cfg     | input     | cfg_index_i, cfg_data_i         | cfg_valid_i & cfg_ready_o
//
// Load: the edge is stored straight from idle. Fetch: scan the chosen marks for the next
// unchosen edge, then look ahead for another to flag the last one.
// Run: seed the union-find RAM, clear the chosen marks and build the heap by sifts; then,
// per extracted edge with both ends in range, find both roots with path compression and
// link them by rank; every step goes through one read port per RAM.
// Reset clears control and counters only; edge and heap RAMs hold no reset.
// Results wait in the output register; the block stalls in its emit step if
// the previous beat has not been taken.
module kruskal_k_group_forest_unit #(
  parameter int unsigned MAX_NODES   = kkgf_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES   = kkgf_pkg::MAX_EDGES_DEF,
  parameter int unsigned WEIGHT_BITS = kkgf_pkg::WEIGHT_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  kkgf_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output kkgf_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [8:0]     cfg_data_i
);
  import kkgf_pkg::*;

  localparam int unsigned EW   = $clog2(MAX_EDGES + 1);
  localparam int unsigned AE   = $clog2(MAX_EDGES);
  localparam int unsigned NW   = $clog2(MAX_NODES + 1);
  localparam int unsigned KW   = EW + 1;
  localparam int unsigned CW   = (EW > NW) ? EW : NW;
  localparam int unsigned WB   = WEIGHT_BITS;
  localparam int unsigned NCAP = (MAX_NODES > 511) ? 511 : MAX_NODES;

  typedef struct packed {
    logic [8:0]    a;
    logic [8:0]    b;
    logic [WB-1:0] w;
    logic [AE-1:0] ord;
  } heap_t;

  typedef struct packed {
    logic [NW-1:0] parent;
    logic [15:0]   rank;
  } uf_t;

  localparam int unsigned HEAP_W = $bits(heap_t);
  localparam int unsigned UF_W   = $bits(uf_t);

  typedef enum logic [26:0] {
    ST_IDLE    = 27'b1 << 0,
    ST_UF_INIT = 27'b1 << 1,
    ST_MK_CLR  = 27'b1 << 2,
    ST_BUILD   = 27'b1 << 3,
    ST_S_LD    = 27'b1 << 4,
    ST_S_V     = 27'b1 << 5,
    ST_S_CHK   = 27'b1 << 6,
    ST_S_L     = 27'b1 << 7,
    ST_S_R     = 27'b1 << 8,
    ST_S_CMP   = 27'b1 << 9,
    ST_X_TOP   = 27'b1 << 10,
    ST_X_M     = 27'b1 << 11,
    ST_X_LAST  = 27'b1 << 12,
    ST_X_SWAP  = 27'b1 << 13,
    ST_X_UNION = 27'b1 << 14,
    ST_F_START = 27'b1 << 15,
    ST_F_UP    = 27'b1 << 16,
    ST_F_CMP   = 27'b1 << 17,
    ST_J_RX    = 27'b1 << 18,
    ST_J_RY    = 27'b1 << 19,
    ST_J_DO    = 27'b1 << 20,
    ST_J_INC   = 27'b1 << 21,
    ST_FT_SCAN = 27'b1 << 22,
    ST_FT_CHK  = 27'b1 << 23,
    ST_FT_NXS  = 27'b1 << 24,
    ST_FT_NXC  = 27'b1 << 25,
    ST_EMIT    = 27'b1 << 26
  } state_e;

  state_e state_q, state_d;

  logic [8:0]    node_count_q, node_count_d;
  logic [8:0]    target_q, target_d;
  logic [EW-1:0] edge_total_q, edge_total_d;
  logic [30:0]   weight_total_q, weight_total_d;
  logic [30:0]   chosen_weight_q, chosen_weight_d;
  logic [EW-1:0] chosen_total_q, chosen_total_d;
  logic [EW-1:0] fetch_q, fetch_d;
  logic [8:0]    groups_q, groups_d;
  logic          out_valid_q, out_valid_d;

  out_t          out_q, out_d;
  out_t          res_q, res_d;
  logic [CW-1:0] i_q, i_d;
  logic [EW-1:0] ext_q, ext_d;
  logic [EW-1:0] top_q, top_d;
  logic [EW-1:0] size_q, size_d;
  logic [EW-1:0] hole_q, hole_d;
  logic [KW-1:0] kid_q, kid_d;
  logic          sift_build_q, sift_build_d;
  heap_t         v_q, v_d;
  heap_t         c_q, c_d;
  heap_t         m_q, m_d;
  logic [NW-1:0] fx_q, fx_d;
  logic [NW-1:0] r_q, r_d;
  logic [NW-1:0] cur_q, cur_d;
  logic [NW-1:0] x_q, x_d;
  logic [NW-1:0] y_q, y_d;
  logic          find_b_q, find_b_d;
  logic [15:0]   rank_q, rank_d;
  logic [EW-1:0] k_q, k_d;
  logic [EW-1:0] nx_q, nx_d;

  logic          ends_we;
  logic [AE-1:0] ends_waddr;
  logic [17:0]   ends_wdata, ends_rdata;
  logic          heap_we;
  logic [EW-1:0] heap_waddr, heap_raddr;
  heap_t         heap_wdata;
  logic [HEAP_W-1:0] heap_rbits;
  heap_t         heap_rdata;
  logic          mark_we;
  logic [AE-1:0] mark_waddr, mark_raddr;
  logic          mark_wdata, mark_rdata;
  logic          uf_we;
  logic [NW-1:0] uf_waddr, uf_raddr;
  uf_t           uf_wdata;
  logic [UF_W-1:0] uf_rbits;
  uf_t           uf_rdata;

  logic [8:0]    n_eff;
  logic [WB-1:0] in_w;
  logic [32:0]   wt_sum, cw_sum;
  logic          m_in_range;

  assign heap_rdata = heap_t'(heap_rbits);
  assign uf_rdata   = uf_t'(uf_rbits);
  assign n_eff      = (node_count_q > 9'(NCAP)) ? 9'(NCAP) : node_count_q;
  assign in_w       = WB'(in_data_i.weight);
  assign wt_sum     = 33'(weight_total_q) + 33'(in_w);
  assign cw_sum     = 33'(chosen_weight_q) + 33'(m_q.w);
  assign m_in_range = (m_q.a != 9'd0) && (m_q.a <= n_eff) &&
                      (m_q.b != 9'd0) && (m_q.b <= n_eff);

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d         = state_q;
    node_count_d    = node_count_q;
    target_d        = target_q;
    edge_total_d    = edge_total_q;
    weight_total_d  = weight_total_q;
    chosen_weight_d = chosen_weight_q;
    chosen_total_d  = chosen_total_q;
    fetch_d         = fetch_q;
    groups_d        = groups_q;
    out_valid_d     = out_valid_q;
    out_d           = out_q;
    res_d           = res_q;
    i_d             = i_q;
    ext_d           = ext_q;
    top_d           = top_q;
    size_d          = size_q;
    hole_d          = hole_q;
    kid_d           = kid_q;
    sift_build_d    = sift_build_q;
    v_d             = v_q;
    c_d             = c_q;
    m_d             = m_q;
    fx_d            = fx_q;
    r_d             = r_q;
    cur_d           = cur_q;
    x_d             = x_q;
    y_d             = y_q;
    find_b_d        = find_b_q;
    rank_d          = rank_q;
    k_d             = k_q;
    nx_d            = nx_q;

    ends_we    = 1'b0;
    ends_waddr = AE'(edge_total_q);
    ends_wdata = {in_data_i.end_a, in_data_i.end_b};
    heap_we    = 1'b0;
    heap_waddr = hole_q;
    heap_wdata = v_q;
    heap_raddr = top_q;
    mark_we    = 1'b0;
    mark_waddr = AE'(i_q);
    mark_wdata = 1'b0;
    mark_raddr = AE'(k_q);
    uf_we      = 1'b0;
    uf_waddr   = cur_q;
    uf_wdata   = '0;
    uf_raddr   = r_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT:    node_count_d = cfg_data_i;
        CFG_TARGET_GROUPS: target_d     = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (in_data_i.mode)
            MODE_LOAD: begin
              if (edge_total_q < EW'(MAX_EDGES)) begin
                ends_we    = 1'b1;
                mark_we    = 1'b1;
                mark_waddr = AE'(edge_total_q);
                heap_we    = 1'b1;
                heap_waddr = edge_total_q + 1'b1;
                heap_wdata = '{a: in_data_i.end_a, b: in_data_i.end_b, w: in_w,
                               ord: AE'(edge_total_q)};
                weight_total_d = wt_sum[32:31] != 2'b00 ? W31_MAX : wt_sum[30:0];
                edge_total_d   = edge_total_q + 1'b1;
              end
            end
            MODE_RUN: begin
              chosen_weight_d = '0;
              chosen_total_d  = '0;
              fetch_d         = '0;
              groups_d        = n_eff;
              i_d             = '0;
              state_d         = ST_UF_INIT;
            end
            MODE_FETCH: begin
              k_d     = fetch_q;
              state_d = ST_FT_SCAN;
            end
            default: ;
          endcase
        end
      end

      // seed every node as its own root with rank zero
      ST_UF_INIT: begin
        uf_we    = 1'b1;
        uf_waddr = NW'(i_q);
        uf_wdata = '{parent: NW'(i_q), rank: '0};
        if (i_q == CW'(MAX_NODES)) begin
          i_d     = '0;
          state_d = ST_MK_CLR;
        end else begin
          i_d = i_q + 1'b1;
        end
      end

      ST_MK_CLR: begin
        if (i_q == CW'(edge_total_q)) begin
          i_d     = CW'(edge_total_q >> 1);
          state_d = ST_BUILD;
        end else begin
          mark_we = 1'b1;
          i_d     = i_q + 1'b1;
        end
      end

      ST_BUILD: begin
        if (i_q == '0) begin
          ext_d   = edge_total_q;
          state_d = ST_X_TOP;
        end else begin
          top_d        = EW'(i_q);
          size_d       = edge_total_q;
          sift_build_d = 1'b1;
          state_d      = ST_S_LD;
        end
      end

      ST_S_LD: begin
        heap_raddr = top_q;
        state_d    = ST_S_V;
      end

      ST_S_V: begin
        v_d     = heap_rdata;
        hole_d  = top_q;
        kid_d   = {top_q, 1'b0};
        state_d = ST_S_CHK;
      end

      ST_S_CHK: begin
        if (kid_q > KW'(size_q)) begin
          heap_we    = 1'b1;
          heap_wdata = v_q;
          if (sift_build_q) begin
            i_d     = i_q - 1'b1;
            state_d = ST_BUILD;
          end else begin
            state_d = ST_X_UNION;
          end
        end else begin
          heap_raddr = EW'(kid_q);
          state_d    = ST_S_L;
        end
      end

      ST_S_L: begin
        c_d = heap_rdata;
        if (kid_q < KW'(size_q)) begin
          heap_raddr = EW'(kid_q + 1'b1);
          state_d    = ST_S_R;
        end else begin
          state_d = ST_S_CMP;
        end
      end

      // on a tie keep the left child
      ST_S_R: begin
        if (c_q.w > heap_rdata.w) begin
          c_d   = heap_rdata;
          kid_d = kid_q + 1'b1;
        end
        state_d = ST_S_CMP;
      end

      ST_S_CMP: begin
        heap_we = 1'b1;
        if (v_q.w > c_q.w) begin
          heap_wdata = c_q;
          hole_d     = EW'(kid_q);
          kid_d      = {kid_q[KW-2:0], 1'b0};
          state_d    = ST_S_CHK;
        end else begin
          heap_wdata = v_q;
          if (sift_build_q) begin
            i_d     = i_q - 1'b1;
            state_d = ST_BUILD;
          end else begin
            state_d = ST_X_UNION;
          end
        end
      end

      ST_X_TOP: begin
        if (ext_q == '0 || groups_q == target_q) begin
          res_d                = '0;
          res_d.kind           = KIND_SUMMARY;
          res_d.dropped_weight = weight_total_q - chosen_weight_q;
          res_d.dropped_count  = 16'(edge_total_q - chosen_total_q);
          state_d              = ST_EMIT;
        end else begin
          heap_raddr = EW'(1);
          state_d    = ST_X_M;
        end
      end

      ST_X_M: begin
        m_d        = heap_rdata;
        heap_raddr = ext_q;
        state_d    = ST_X_LAST;
      end

      ST_X_LAST: begin
        heap_we    = 1'b1;
        heap_waddr = EW'(1);
        heap_wdata = heap_rdata;
        state_d    = ST_X_SWAP;
      end

      // park the minimum in the freed last slot
      ST_X_SWAP: begin
        heap_we    = 1'b1;
        heap_waddr = ext_q;
        heap_wdata = m_q;
        ext_d      = ext_q - 1'b1;
        if (ext_q > EW'(1)) begin
          top_d        = EW'(1);
          size_d       = ext_q - 1'b1;
          sift_build_d = 1'b0;
          state_d      = ST_S_LD;
        end else begin
          state_d = ST_X_UNION;
        end
      end

      ST_X_UNION: begin
        if (m_in_range) begin
          fx_d     = NW'(m_q.a);
          find_b_d = 1'b0;
          state_d  = ST_F_START;
        end else begin
          state_d = ST_X_TOP;
        end
      end

      ST_F_START: begin
        r_d      = fx_q;
        uf_raddr = fx_q;
        state_d  = ST_F_UP;
      end

      ST_F_UP: begin
        if (uf_rdata.parent == r_q) begin
          cur_d    = fx_q;
          uf_raddr = fx_q;
          state_d  = ST_F_CMP;
        end else begin
          r_d      = uf_rdata.parent;
          uf_raddr = uf_rdata.parent;
        end
      end

      // point each node on the path straight at the root
      ST_F_CMP: begin
        if (uf_rdata.parent == r_q) begin
          if (!find_b_q) begin
            x_d      = r_q;
            fx_d     = NW'(m_q.b);
            find_b_d = 1'b1;
            state_d  = ST_F_START;
          end else begin
            y_d     = r_q;
            state_d = ST_J_RX;
          end
        end else begin
          uf_we    = 1'b1;
          uf_waddr = cur_q;
          uf_wdata = '{parent: r_q, rank: uf_rdata.rank};
          cur_d    = uf_rdata.parent;
          uf_raddr = uf_rdata.parent;
        end
      end

      ST_J_RX: begin
        uf_raddr = x_q;
        state_d  = ST_J_RY;
      end

      ST_J_RY: begin
        rank_d   = uf_rdata.rank;
        uf_raddr = y_q;
        state_d  = ST_J_DO;
      end

      ST_J_DO: begin
        uf_we   = 1'b1;
        state_d = ST_X_TOP;
        if (rank_q > uf_rdata.rank) begin
          uf_waddr = y_q;
          uf_wdata = '{parent: x_q, rank: uf_rdata.rank};
        end else begin
          uf_waddr = x_q;
          uf_wdata = '{parent: y_q, rank: rank_q};
          if (rank_q == uf_rdata.rank && uf_rdata.rank != RANK_MAX) begin
            rank_d  = uf_rdata.rank + 1'b1;
            state_d = ST_J_INC;
          end
        end
        if (x_q != y_q) begin
          mark_we         = 1'b1;
          mark_waddr      = m_q.ord;
          mark_wdata      = 1'b1;
          chosen_weight_d = cw_sum[32:31] != 2'b00 ? W31_MAX : cw_sum[30:0];
          chosen_total_d  = chosen_total_q + 1'b1;
          groups_d        = groups_q - 1'b1;
        end
      end

      ST_J_INC: begin
        uf_we    = 1'b1;
        uf_waddr = y_q;
        uf_wdata = '{parent: y_q, rank: rank_q};
        state_d  = ST_X_TOP;
      end

      ST_FT_SCAN: begin
        if (k_q >= edge_total_q) begin
          fetch_d    = edge_total_q;
          res_d      = '0;
          res_d.kind = KIND_NONE;
          state_d    = ST_EMIT;
        end else begin
          mark_raddr = AE'(k_q);
          state_d    = ST_FT_CHK;
        end
      end

      ST_FT_CHK: begin
        if (mark_rdata) begin
          k_d     = k_q + 1'b1;
          state_d = ST_FT_SCAN;
        end else begin
          res_d       = '0;
          res_d.kind  = KIND_EDGE;
          res_d.out_a = ends_rdata[17:9];
          res_d.out_b = ends_rdata[8:0];
          nx_d        = k_q + 1'b1;
          state_d     = ST_FT_NXS;
        end
      end

      // look ahead for another unchosen edge to flag the last one
      ST_FT_NXS: begin
        if (nx_q >= edge_total_q) begin
          res_d.is_last = 1'b1;
          fetch_d       = k_q + 1'b1;
          state_d       = ST_EMIT;
        end else begin
          mark_raddr = AE'(nx_q);
          state_d    = ST_FT_NXC;
        end
      end

      ST_FT_NXC: begin
        if (mark_rdata) begin
          nx_d    = nx_q + 1'b1;
          state_d = ST_FT_NXS;
        end else begin
          fetch_d = k_q + 1'b1;
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      node_count_q    <= NODE_COUNT_RST;
      target_q        <= TARGET_RST;
      edge_total_q    <= '0;
      weight_total_q  <= '0;
      chosen_weight_q <= '0;
      chosen_total_q  <= '0;
      fetch_q         <= '0;
      groups_q        <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      node_count_q    <= node_count_d;
      target_q        <= target_d;
      edge_total_q    <= edge_total_d;
      weight_total_q  <= weight_total_d;
      chosen_weight_q <= chosen_weight_d;
      chosen_total_q  <= chosen_total_d;
      fetch_q         <= fetch_d;
      groups_q        <= groups_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    res_q        <= res_d;
    i_q          <= i_d;
    ext_q        <= ext_d;
    top_q        <= top_d;
    size_q       <= size_d;
    hole_q       <= hole_d;
    kid_q        <= kid_d;
    sift_build_q <= sift_build_d;
    v_q          <= v_d;
    c_q          <= c_d;
    m_q          <= m_d;
    fx_q         <= fx_d;
    r_q          <= r_d;
    cur_q        <= cur_d;
    x_q          <= x_d;
    y_q          <= y_d;
    find_b_q     <= find_b_d;
    rank_q       <= rank_d;
    k_q          <= k_d;
    nx_q         <= nx_d;
  end

  kkgf_ram #(.DATA_W(18), .DEPTH(MAX_EDGES)) u_ends_ram (
    .clk_i   (clk_i),
    .we_i    (ends_we),
    .waddr_i (ends_waddr),
    .wdata_i (ends_wdata),
    .raddr_i (AE'(k_q)),
    .rdata_o (ends_rdata)
  );

  kkgf_ram #(.DATA_W(HEAP_W), .DEPTH(MAX_EDGES + 1)) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (HEAP_W'(heap_wdata)),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rbits)
  );

  kkgf_ram #(.DATA_W(1), .DEPTH(MAX_EDGES)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  kkgf_ram #(.DATA_W(UF_W), .DEPTH(MAX_NODES + 1)) u_uf_ram (
    .clk_i   (clk_i),
    .we_i    (uf_we),
    .waddr_i (uf_waddr),
    .wdata_i (UF_W'(uf_wdata)),
    .raddr_i (uf_raddr),
    .rdata_o (uf_rbits)
  );

  a_chosen_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_total_q <= edge_total_q)
    else $error("chosen edge count exceeds loaded edge count");

  a_fetch_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch_q <= edge_total_q)
    else $error("fetch pointer beyond loaded edges");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit step");

  a_kid_of_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_S_CMP) |-> (kid_q == {hole_q, 1'b0} || kid_q == {hole_q, 1'b1}))
    else $error("sift child index does not follow hole");

endmodule
